@@ design/ple_pkg.sv @@
// ----------------------------------------------------------------------------
// ple_pkg
// Shared sizes, command codes and sequencer states of the positional list
// engine.
// ----------------------------------------------------------------------------
package ple_pkg;

    // list storage sizes
    localparam int DEPTH       = 64;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int CNT_W       = 7;
    localparam int VALUE_WIDTH = 32;
    localparam int CMD_W       = 3;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_GET    = 3'd0,
        CMD_SET    = 3'd1,
        CMD_INSERT = 3'd2,
        CMD_REMOVE = 3'd3,
        CMD_SEARCH = 3'd4
    } cmd_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_FINAL,
        ST_FINISH
    } state_t;

endpackage

@@ design/positional_list_engine_core.sv @@
// ----------------------------------------------------------------------------
// positional_list_engine_core
// Bounded packed list with 1-based positions: get, set, insert after a
// position, remove and search, one result item per command item.
// ----------------------------------------------------------------------------
// Usage
//   Input channel: in_valid / in_stall with command, position, value. The
//   block stalls the input while a command is being worked on.
//   Output channel: out_valid / out_stall with ok, read_value,
//   found_position, list_length. The result is held in an output register,
//   so a new item is taken while a result still waits for the receiver.
//   Configuration: cfg_we / cfg_wdata write the capacity register
//   (reset 64); the effective bound is the smaller of capacity and DEPTH.
// Operation
//   One single-port-write, registered-read store is walked by one cursor,
//   one entry per cycle. Set writes the entry at once; get reads one entry;
//   insert moves the entries after the position up by one, then writes the
//   value; remove moves the entries after the position down by one; search
//   reads until the first match or the end of the list. A command that
//   fails its check goes straight to the result.
// Reset
//   rst_n clears the length to zero and capacity to 64; the store contents
//   are not cleared. A stalled result keeps its value; a finished command
//   waits in place until the output register is free.
// ----------------------------------------------------------------------------
module positional_list_engine_core (
    input  logic                              clk,
    input  logic                              rst_n,
    // command items
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [ple_pkg::CMD_W-1:0]         command,
    input  logic [ple_pkg::CNT_W-1:0]         position,
    input  logic [ple_pkg::VALUE_WIDTH-1:0]   value,
    // result items
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              ok,
    output logic [ple_pkg::VALUE_WIDTH-1:0]   read_value,
    output logic [ple_pkg::CNT_W-1:0]         found_position,
    output logic [ple_pkg::CNT_W-1:0]         list_length,
    // capacity register
    input  logic                              cfg_we,
    input  logic [ple_pkg::CNT_W-1:0]         cfg_wdata
);
    import ple_pkg::*;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] ONE_CNT   = CNT_W'(1);
    localparam logic [ADDR_W-1:0] ONE_ADDR = ADDR_W'(1);

    // control registers
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   cap_reg;
    logic               active_reg, active_next;
    logic               pend_reg, pend_next;
    logic               first_reg, first_next;
    logic               issue_first_reg, issue_first_next;
    logic               out_valid_reg, out_valid_next;

    // payload registers
    cmd_t                   cmd_reg;
    logic [CNT_W-1:0]       pos_reg;
    logic [VALUE_WIDTH-1:0] val_reg;
    logic [ADDR_W-1:0]      cur_reg, cur_next;
    logic [ADDR_W-1:0]      last_reg, last_next;
    logic [ADDR_W-1:0]      pend_addr_reg, pend_addr_next;
    logic                   res_ok_reg, res_ok_next;
    logic [VALUE_WIDTH-1:0] res_rd_reg, res_rd_next;
    logic [CNT_W-1:0]       res_found_reg, res_found_next;
    logic                   ok_reg, ok_next;
    logic [VALUE_WIDTH-1:0] rd_out_reg, rd_out_next;
    logic [CNT_W-1:0]       found_out_reg, found_out_next;
    logic [CNT_W-1:0]       len_out_reg, len_out_next;

    // store ports
    logic [VALUE_WIDTH-1:0] mem [DEPTH];
    logic [VALUE_WIDTH-1:0] rd_data_reg;
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    logic [VALUE_WIDTH-1:0] mem_wdata;
    logic                   mem_re;
    logic [ADDR_W-1:0]      mem_raddr;

    logic                   in_accept;
    logic                   pos_in_list;
    logic [CNT_W-1:0]       bound;

    assign in_accept   = in_valid && (state_reg == ST_IDLE);
    assign bound       = (cap_reg < DEPTH_CNT) ? cap_reg : DEPTH_CNT;
    assign pos_in_list = (pos_reg >= ONE_CNT) && (pos_reg <= count_reg);

    // store: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            count_reg       <= '0;
            cap_reg         <= DEPTH_CNT;
            active_reg      <= 1'b0;
            pend_reg        <= 1'b0;
            first_reg       <= 1'b0;
            issue_first_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            active_reg      <= active_next;
            pend_reg        <= pend_next;
            first_reg       <= first_next;
            issue_first_reg <= issue_first_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    // payload state
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg <= cmd_t'(command);
            pos_reg <= position;
            val_reg <= value;
        end
        cur_reg       <= cur_next;
        last_reg      <= last_next;
        pend_addr_reg <= pend_addr_next;
        res_ok_reg    <= res_ok_next;
        res_rd_reg    <= res_rd_next;
        res_found_reg <= res_found_next;
        ok_reg        <= ok_next;
        rd_out_reg    <= rd_out_next;
        found_out_reg <= found_out_next;
        len_out_reg   <= len_out_next;
    end

    // sequencer: next state, cursor and store controls
    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        active_next      = active_reg;
        pend_next        = pend_reg;
        first_next       = first_reg;
        issue_first_next = issue_first_reg;
        cur_next         = cur_reg;
        last_next        = last_reg;
        pend_addr_next   = pend_addr_reg;
        res_ok_next      = res_ok_reg;
        res_rd_next      = res_rd_reg;
        res_found_next   = res_found_reg;
        ok_next          = ok_reg;
        rd_out_next      = rd_out_reg;
        found_out_next   = found_out_reg;
        len_out_next     = len_out_reg;
        mem_we           = 1'b0;
        mem_waddr        = ADDR_W'(pos_reg - ONE_CNT);
        mem_wdata        = val_reg;
        mem_re           = 1'b0;
        mem_raddr        = cur_reg;

        // output register drains when taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_EXEC;
                end
            end

            // check the command, write the entry for set, and set up the cursor range
            ST_EXEC:
            begin
                res_ok_next      = 1'b0;
                res_rd_next      = '0;
                res_found_next   = '0;
                active_next      = 1'b1;
                pend_next        = 1'b0;
                issue_first_next = 1'b1;
                state_next       = ST_FINISH;
                case (cmd_reg)
                    CMD_GET:
                    begin
                        if (pos_in_list)
                        begin
                            res_ok_next = 1'b1;
                            cur_next    = ADDR_W'(pos_reg - ONE_CNT);
                            last_next   = ADDR_W'(pos_reg - ONE_CNT);
                            state_next  = ST_SCAN;
                        end
                    end
                    CMD_SET:
                    begin
                        if (pos_in_list)
                        begin
                            res_ok_next = 1'b1;
                            mem_we      = 1'b1;
                        end
                    end
                    CMD_INSERT:
                    begin
                        if ((count_reg < bound) && (pos_reg <= count_reg))
                        begin
                            res_ok_next = 1'b1;
                            if (count_reg > pos_reg)
                            begin
                                cur_next   = ADDR_W'(count_reg - ONE_CNT);
                                last_next  = ADDR_W'(pos_reg);
                                state_next = ST_SCAN;
                            end
                            else
                            begin
                                state_next = ST_FINAL;
                            end
                        end
                    end
                    CMD_REMOVE:
                    begin
                        if (pos_in_list)
                        begin
                            res_ok_next = 1'b1;
                            cur_next    = ADDR_W'(pos_reg - ONE_CNT);
                            last_next   = ADDR_W'(count_reg - ONE_CNT);
                            state_next  = ST_SCAN;
                        end
                    end
                    CMD_SEARCH:
                    begin
                        if (count_reg != '0)
                        begin
                            cur_next   = '0;
                            last_next  = ADDR_W'(count_reg - ONE_CNT);
                            state_next = ST_SCAN;
                        end
                    end
                    default:
                    begin
                        state_next = ST_FINISH;
                    end
                endcase
            end

            // walk the store: read at the cursor, retire last cycle's read
            ST_SCAN:
            begin
                // retire the read issued in the previous cycle
                if (pend_reg)
                begin
                    case (cmd_reg)
                        CMD_INSERT:
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = pend_addr_reg;
                            mem_wdata = rd_data_reg;
                        end
                        CMD_REMOVE:
                        begin
                            if (first_reg)
                            begin
                                res_rd_next = rd_data_reg;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = pend_addr_reg;
                                mem_wdata = rd_data_reg;
                            end
                        end
                        CMD_GET:
                        begin
                            res_rd_next = rd_data_reg;
                        end
                        default:
                        begin
                        end
                    endcase
                end

                // issue the next read
                if (active_reg)
                begin
                    mem_re           = 1'b1;
                    pend_next        = 1'b1;
                    first_next       = issue_first_reg;
                    issue_first_next = 1'b0;
                    if (cmd_reg == CMD_INSERT)
                    begin
                        pend_addr_next = cur_reg + ONE_ADDR;
                        cur_next       = cur_reg - ONE_ADDR;
                    end
                    else if (cmd_reg == CMD_REMOVE)
                    begin
                        pend_addr_next = cur_reg - ONE_ADDR;
                        cur_next       = cur_reg + ONE_ADDR;
                    end
                    else
                    begin
                        pend_addr_next = cur_reg;
                        cur_next       = cur_reg + ONE_ADDR;
                    end
                    if (cur_reg == last_reg)
                    begin
                        active_next = 1'b0;
                    end
                end
                else
                begin
                    pend_next = 1'b0;
                end

                // end of walk, or first match for search
                if (pend_reg && (cmd_reg == CMD_SEARCH) && (rd_data_reg == val_reg))
                begin
                    res_ok_next    = 1'b1;
                    res_found_next = CNT_W'(pend_addr_reg) + ONE_CNT;
                    active_next    = 1'b0;
                    pend_next      = 1'b0;
                    state_next     = ST_FINISH;
                end
                else if (pend_reg && !active_reg)
                begin
                    pend_next = 1'b0;
                    if (cmd_reg == CMD_INSERT)
                    begin
                        state_next = ST_FINAL;
                    end
                    else
                    begin
                        if (cmd_reg == CMD_REMOVE)
                        begin
                            count_next = count_reg - ONE_CNT;
                        end
                        state_next = ST_FINISH;
                    end
                end
            end

            // insert: place the new value in the opened slot
            ST_FINAL:
            begin
                mem_we     = 1'b1;
                mem_waddr  = ADDR_W'(pos_reg);
                count_next = count_reg + ONE_CNT;
                state_next = ST_FINISH;
            end

            // hand the result to the output register once it is free
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    ok_next        = res_ok_reg;
                    rd_out_next    = res_rd_reg;
                    found_out_next = res_found_reg;
                    len_out_next   = count_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ports
    assign in_stall       = (state_reg != ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign ok             = ok_reg;
    assign read_value     = rd_out_reg;
    assign found_position = found_out_reg;
    assign list_length    = len_out_reg;

endmodule
